// File: rtl/core/ust_pkg.sv
// Package of the UV sphere tessellator core: widths, arithmetic constants,
// register indexes, pipeline record types and small helper functions.
// No dependencies.
`default_nettype none
package ust_pkg;

  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned MAX_COUNT  = 256;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned CORNER_W   = 3;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned DIV_W      = COUNT_W + 1;
  localparam int unsigned DIV_NUM_W  = 42;
  localparam int unsigned DIV_CELLS  = DIV_NUM_W;
  localparam int unsigned SINE_LAT   = 8;
  localparam int unsigned MUL_LAT    = 2;
  localparam int unsigned PIPE_LAT   = DIV_CELLS + SINE_LAT + MUL_LAT + 1;
  localparam int unsigned Q_W        = 31;
  localparam int unsigned SIN_W      = 16;

  localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [Q_W-1:0] COEF1   = 31'd1686629713;
  localparam logic [Q_W-1:0] COEF3   = 31'd693598668;
  localparam logic [Q_W-1:0] COEF5   = 31'd85569306;
  localparam logic [Q_W-1:0] COEF7   = 31'd5026996;
  localparam logic [Q_W-1:0] COEF9   = 31'd172272;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

  typedef enum logic [1:0] {
    REG_RADIUS     = 2'd0,
    REG_LAT_COUNT  = 2'd1,
    REG_LONG_COUNT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_NUM_W-1:0] num;
    logic [ANGLE_W-1:0]   quo;
  } div_stage_t;

  typedef struct packed {
    logic                vld;
    logic [CORNER_W-1:0] corner;
  } tag_t;

  typedef struct packed {
    logic [Q_W-1:0] t;
    logic [1:0]     q;
    logic [Q_W-1:0] t2;
    logic [Q_W-1:0] r;
  } sine_stage_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] res;
    if (v < COUNT_W'(3)) begin
      res = COUNT_W'(3);
    end else if (v > COUNT_W'(MAX_COUNT)) begin
      res = COUNT_W'(MAX_COUNT);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Corners 1, 2 and 4 take the next latitude; corners 2, 4 and 5 the next longitude.
  function automatic logic lat_step(input logic [CORNER_W-1:0] c);
    return (c == 3'd1) || (c == 3'd2) || (c == 3'd4);
  endfunction

  function automatic logic long_step(input logic [CORNER_W-1:0] c);
    return (c == 3'd2) || (c == 3'd4) || (c == 3'd5);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ust_cell_if.sv
// Input channel of the UV sphere tessellator: one sphere cell per item.
// Depends on ust_pkg.
`default_nettype none
interface ust_cell_if import ust_pkg::*;;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] lat_index;
  logic [INDEX_W-1:0] long_index;
  modport source (output valid, lat_index, long_index, input ready);
  modport sink (input valid, lat_index, long_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ust_vert_if.sv
// Output channel of the UV sphere tessellator: one vertex per item.
// Depends on ust_pkg.
`default_nettype none
interface ust_vert_if import ust_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  vx;
  logic signed [COORD_W-1:0]  vy;
  logic signed [COORD_W-1:0]  vz;
  logic [CORNER_W-1:0]        corner;
  logic                       last_vertex;
  modport source (output valid, vx, vy, vz, corner, last_vertex, input ready);
  modport sink (input valid, vx, vy, vz, corner, last_vertex, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ust_div_cell.sv
// One restoring division step: a single quotient bit per cell and enabled cycle.
// Depends on ust_pkg.
`default_nettype none
module ust_div_cell import ust_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DIV_W-1:0] div_i,
  input  wire div_stage_t       stage_i,
  output div_stage_t            stage_o
);

  div_stage_t stage_q, stage_d;
  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {stage_i.rem, stage_i.num[DIV_NUM_W-1]};
    diff  = trial - {1'b0, div_i};
    ge    = trial >= {1'b0, div_i};
    stage_d.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    stage_d.num = {stage_i.num[DIV_NUM_W-2:0], 1'b0};
    stage_d.quo = {stage_i.quo[ANGLE_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

// File: rtl/core/ust_sine.sv
// Pipelined Q1.15 sine of a 32-bit turn angle, quarter wave by a Taylor
// series in Q30 with at most one multiplication per stage. Depends on ust_pkg.
`default_nettype none
module ust_sine import ust_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [ANGLE_W-1:0] angle_i,
  output logic signed [SIN_W-1:0] sine_o
);

  sine_stage_t st_q [6];
  logic [1:0]        q6_q;
  logic [Q_W-1:0]    s_q;
  logic signed [SIN_W-1:0] out_q;

  logic [Q_W-1:0]    x0;
  logic [2*Q_W-1:0]  m1, m2, m3, m4, m5, m6;
  logic [ANGLE_W-1:0] rnd;
  logic [COORD_W-1:0] v;
  logic [SIN_W-2:0]  mag;

  always_comb begin
    x0  = {1'b0, angle_i[29:0]};
    m1  = st_q[0].t * st_q[0].t;
    m2  = st_q[1].t2 * COEF9;
    m3  = st_q[2].t2 * st_q[2].r;
    m4  = st_q[3].t2 * st_q[3].r;
    m5  = st_q[4].t2 * st_q[4].r;
    m6  = st_q[5].t * st_q[5].r;
    rnd = {1'b0, s_q} + ANGLE_W'(16384);
    v   = rnd[31:15];
    mag = (v > COORD_W'(32767)) ? 15'h7fff : v[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= '{t: (angle_i[30] ? (Q30_ONE - x0) : x0), q: angle_i[31:30],
                   t2: '0, r: '0};
      st_q[1] <= '{t: st_q[0].t, q: st_q[0].q, t2: m1[60:30], r: st_q[0].r};
      st_q[2] <= '{t: st_q[1].t, q: st_q[1].q, t2: st_q[1].t2, r: COEF7 - m2[60:30]};
      st_q[3] <= '{t: st_q[2].t, q: st_q[2].q, t2: st_q[2].t2, r: COEF5 - m3[60:30]};
      st_q[4] <= '{t: st_q[3].t, q: st_q[3].q, t2: st_q[3].t2, r: COEF3 - m4[60:30]};
      st_q[5] <= '{t: st_q[4].t, q: st_q[4].q, t2: st_q[4].t2, r: COEF1 - m5[60:30]};
      s_q     <= m6[60:30];
      q6_q    <= st_q[5].q;
      out_q   <= q6_q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sine_o = out_q;

endmodule
`default_nettype wire

// File: rtl/core/uv_sphere_tessellator_core.sv
// Top level of the UV sphere tessellator: configuration registers, vertex
// sequencer, two chains of division cells, four sine pipelines and the
// coordinate multipliers. Depends on ust_pkg, ust_cell_if, ust_vert_if,
// ust_div_cell and ust_sine.
//
//   channel    direction  handshake      payload
//   cell_in    in         valid/ready    lat_index, long_index
//   vert_out   out        valid/ready    vx, vy, vz, corner, last_vertex
//   apb        in         psel/penable   paddr, pwdata, prdata (pready high)
//
// A cell is taken when the sequencer is idle or at its last corner; the
// sequencer issues one vertex a cycle unless the output stalls. A vertex passes
// 42 division cells, 8 sine stages, 2 multiplier stages and the output register.
// The whole pipeline holds while a finished vertex waits to be taken.
// Reset restores radius 256 and both counts 16 and empties the pipeline.
`default_nettype none
module uv_sphere_tessellator_core import ust_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ust_cell_if.sink         cell_in,
  ust_vert_if.source       vert_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [RADIUS_W-1:0] radius_q;
  logic [COUNT_W-1:0]  lat_count_q, long_count_q;
  logic                wr_en;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= RADIUS_W'(256);
      lat_count_q  <= COUNT_W'(16);
      long_count_q <= COUNT_W'(16);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIUS:     radius_q     <= pwdata[RADIUS_W-1:0];
        REG_LAT_COUNT:  lat_count_q  <= clamp_count(pwdata[COUNT_W-1:0]);
        REG_LONG_COUNT: long_count_q <= clamp_count(pwdata[COUNT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS:     prdata = {16'd0, radius_q};
      REG_LAT_COUNT:  prdata = {23'd0, lat_count_q};
      REG_LONG_COUNT: prdata = {23'd0, long_count_q};
      default:        prdata = '0;
    endcase
  end

  tag_t tag_q [PIPE_LAT];
  logic adv;
  logic accept;
  logic busy_q;
  logic [CORNER_W-1:0] slot_q;
  logic [INDEX_W-1:0]  lat_q, long_q;
  logic                last_slot;

  assign adv       = !tag_q[PIPE_LAT-1].vld || vert_out.ready;
  assign last_slot = slot_q == LAST_CORNER;
  assign cell_in.ready = adv && (!busy_q || last_slot);
  assign accept    = cell_in.valid && cell_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else if (adv) begin
      if (accept) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end else if (busy_q) begin
        busy_q <= !last_slot;
        slot_q <= last_slot ? '0 : slot_q + CORNER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q  <= cell_in.lat_index;
      long_q <= cell_in.long_index;
    end
  end

  logic [COUNT_W-1:0] n_lat, n_long;
  div_stage_t phi_chain [DIV_CELLS+1];
  div_stage_t theta_chain [DIV_CELLS+1];

  always_comb begin
    n_lat  = {1'b0, lat_q} + COUNT_W'(lat_step(slot_q));
    n_long = {1'b0, long_q} + COUNT_W'(long_step(slot_q));
    phi_chain[0].rem   = '0;
    phi_chain[0].num   = {1'b0, n_lat, 23'd0, lat_count_q};
    phi_chain[0].quo   = '0;
    theta_chain[0].rem = '0;
    theta_chain[0].num = {n_long, 24'd0, long_count_q};
    theta_chain[0].quo = '0;
  end

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    ust_div_cell u_phi_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .div_i   ({lat_count_q, 1'b0}),
      .stage_i (phi_chain[k]),
      .stage_o (phi_chain[k+1])
    );
    ust_div_cell u_theta_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .div_i   ({long_count_q, 1'b0}),
      .stage_i (theta_chain[k]),
      .stage_o (theta_chain[k+1])
    );
  end

  logic [ANGLE_W-1:0] phi, theta;
  logic signed [SIN_W-1:0] sp, cp, st, ct;

  assign phi   = phi_chain[DIV_CELLS].quo;
  assign theta = theta_chain[DIV_CELLS].quo;

  ust_sine u_sin_phi (.clk_i(clk_i), .en_i(adv), .angle_i(phi), .sine_o(sp));
  ust_sine u_cos_phi (.clk_i(clk_i), .en_i(adv), .angle_i(phi + QUARTER_TURN), .sine_o(cp));
  ust_sine u_sin_theta (.clk_i(clk_i), .en_i(adv), .angle_i(theta), .sine_o(st));
  ust_sine u_cos_theta (
    .clk_i(clk_i), .en_i(adv), .angle_i(theta + QUARTER_TURN), .sine_o(ct)
  );

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [48:0] p,
    input int unsigned        sh
  );
    logic [48:0] mag;
    logic [48:0] sum;
    logic [48:0] v;
    logic [COORD_W-2:0] lim;
    mag = p[48] ? 49'(-p) : 49'(p);
    sum = mag + (49'd1 << (sh - 1));
    v   = sum >> sh;
    lim = (v > 49'd65535) ? 16'hffff : v[COORD_W-2:0];
    return p[48] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
  endfunction

  logic signed [32:0] rsp_q, yp_q, yp1_q;
  logic signed [SIN_W-1:0] st_q, ct_q;
  logic signed [48:0] xp_q, zp_q;
  logic signed [COORD_W-1:0] vx_q, vy_q, vz_q;
  logic signed [RADIUS_W:0] rad_s;

  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rad_s * sp;
      yp_q  <= rad_s * cp;
      st_q  <= st;
      ct_q  <= ct;
      xp_q  <= rsp_q * ct_q;
      zp_q  <= rsp_q * st_q;
      yp1_q <= yp_q;
      vx_q  <= round_sat(xp_q, 30);
      vy_q  <= round_sat(49'(yp1_q), 15);
      vz_q  <= round_sat(zp_q, 30);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        tag_q[k] <= '0;
      end
    end else if (adv) begin
      tag_q[0].vld    <= busy_q;
      tag_q[0].corner <= slot_q;
      for (int k = 1; k < PIPE_LAT; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign vert_out.valid       = tag_q[PIPE_LAT-1].vld;
  assign vert_out.corner      = tag_q[PIPE_LAT-1].corner;
  assign vert_out.last_vertex = tag_q[PIPE_LAT-1].corner == LAST_CORNER;
  assign vert_out.vx          = vx_q;
  assign vert_out.vy          = vy_q;
  assign vert_out.vz          = vz_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && slot_q == '0)
    else $error("accepted item did not start at corner zero");
  a_slot_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && adv && !last_slot |=> busy_q && slot_q == $past(slot_q) + CORNER_W'(1))
    else $error("sequencer skipped a corner");
  a_out_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_out.valid |-> vert_out.corner <= LAST_CORNER)
    else $error("output corner out of range");
`endif

endmodule
`default_nettype wire

// File: bench/ust_vertex_checker.sv
// Vertex checker for the UV sphere tessellator: watches the cell and vertex
// channels, predicts each cell's six vertices and compares them in order.
// Depends on ust_pkg, ust_cell_if and ust_vert_if.
module ust_vertex_checker import ust_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  reg_idx_e        cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            cell_valid_i,
  input  logic            cell_ready_i,
  input  logic [7:0]      cell_lat_i,
  input  logic [7:0]      cell_long_i,
  ust_vert_if             vert,
  output int              fail_count_o,
  output int              pending_o,
  output int              vertex_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic [CORNER_W-1:0]       corner;
    logic                      last_vertex;
  } vertex_t;

  vertex_t     expected_vertices[$];
  logic [15:0] radius_q;
  logic [8:0]  lats_q;
  logic [8:0]  longs_q;

  assign pending_o = expected_vertices.size();

  function automatic longint quarter_wave(longint unsigned t);
    longint unsigned t2, r, s;
    t2 = (t * t) >> 30;
    r = 64'd5026996 - ((t2 * 64'd172272) >> 30);
    r = 64'd85569306 - ((t2 * r) >> 30);
    r = 64'd693598668 - ((t2 * r) >> 30);
    r = 64'd1686629713 - ((t2 * r) >> 30);
    s = (t * r) >> 30;
    s = (s + 16384) >> 15;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint sine_of_turn(logic [31:0] a);
    longint v;
    longint unsigned x;
    x = longint'(a[29:0]);
    v = a[30] ? quarter_wave(64'd1073741824 - x) : quarter_wave(x);
    return a[31] ? -v : v;
  endfunction

  function automatic logic [16:0] scaled(longint p, int sh);
    longint unsigned half, m;
    longint v;
    half = 64'd1 << (sh - 1);
    if (p < 0) begin
      m = longint'(-p);
      v = -longint'((m + half) >> sh);
    end else begin
      m = p;
      v = longint'((m + half) >> sh);
    end
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[16:0];
  endfunction

  function automatic vertex_t corner_vertex(int k, longint unsigned i, longint unsigned j);
    logic [31:0] phi, theta;
    longint sp, cp, st, ct, r;
    vertex_t v;
    phi = 32'(((i << 32) + lats_q) / (2 * longint'(lats_q)));
    theta = 32'(((j << 33) + longs_q) / (2 * longint'(longs_q)));
    sp = sine_of_turn(phi);
    cp = sine_of_turn(phi + QUARTER_TURN);
    st = sine_of_turn(theta);
    ct = sine_of_turn(theta + QUARTER_TURN);
    r = longint'(radius_q);
    v.vx = scaled(r * sp * ct, 30);
    v.vy = scaled(r * cp, 15);
    v.vz = scaled(r * sp * st, 30);
    v.corner = CORNER_W'(k);
    v.last_vertex = (k == 5);
    return v;
  endfunction

  function automatic void enqueue_vertex(vertex_t v);
    expected_vertices.insert(expected_vertices.size(), v);
  endfunction

  function automatic logic [8:0] limited_count(logic [8:0] v);
    if (v < 3) return 9'd3;
    if (v > MAX_COUNT) return 9'(MAX_COUNT);
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint unsigned i, j;
    vertex_t got, want;
    if (!rst_ni) begin
      radius_q <= 16'd256;
      lats_q <= 9'd16;
      longs_q <= 9'd16;
      fail_count_o <= 0;
      vertex_count_o <= 0;
      expected_vertices.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS: radius_q <= cfg_data_i[15:0];
          REG_LAT_COUNT: lats_q <= limited_count(cfg_data_i[8:0]);
          REG_LONG_COUNT: longs_q <= limited_count(cfg_data_i[8:0]);
          default: ;
        endcase
      end
      if (cell_valid_i && cell_ready_i) begin
        i = cell_lat_i;
        j = cell_long_i;
        enqueue_vertex(corner_vertex(0, i, j));
        enqueue_vertex(corner_vertex(1, i + 1, j));
        enqueue_vertex(corner_vertex(2, i + 1, j + 1));
        enqueue_vertex(corner_vertex(3, i, j));
        enqueue_vertex(corner_vertex(4, i + 1, j + 1));
        enqueue_vertex(corner_vertex(5, i, j + 1));
      end
      if (vert.valid && vert.ready) begin
        got = '{vert.vx, vert.vy, vert.vz, vert.corner, vert.last_vertex};
        vertex_count_o <= vertex_count_o + 1;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            $display("%0t: vertex mismatch expected %p actual %p", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: bench/tb.sv
// Testbench top for the UV sphere tessellator: makes reset, register writes
// and cell stimulus with random idling, and gives the verdict.
// Depends on ust_pkg, ust_cell_if, ust_vert_if, the core and the checker.
module tb import ust_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, vertex_count;
  int          cells_sent;
  logic        quiet;
  reg_idx_e    wr_idx;

  ust_cell_if cell_in();
  ust_vert_if vert_out();

  uv_sphere_tessellator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cell_in(cell_in), .vert_out(vert_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  assign wr_idx = reg_idx_e'(paddr[3:2]);

  ust_vertex_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_idx_i(wr_idx),
    .cfg_data_i(pwdata), .cell_valid_i(cell_in.valid), .cell_ready_i(cell_in.ready),
    .cell_lat_i(cell_in.lat_index), .cell_long_i(cell_in.long_index),
    .vert(vert_out), .fail_count_o(fail_count), .pending_o(pending),
    .vertex_count_o(vertex_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  // The receiver stalls in random bursts until the quiet part of the run.
  initial begin
    int n;
    vert_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        vert_out.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      vert_out.ready <= 1'b1;
    end
  end

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The valid line stays high between items that follow without idling.
  task automatic send_cell(logic [7:0] lat, logic [7:0] lon);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      cell_in.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    cell_in.valid <= 1'b1;
    cell_in.lat_index <= lat;
    cell_in.long_index <= lon;
    do @(posedge clk_i); while (!cell_in.ready);
    cells_sent++;
  endtask

  task automatic drain;
    cell_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_cells(int count, int lat_max, int long_max);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0)
        send_cell(8'($urandom), 8'($urandom));
      else
        send_cell(8'($urandom_range(0, lat_max)), 8'($urandom_range(0, long_max)));
    end
  endtask

  initial begin
    quiet = 1'b0;
    cells_sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cell_in.valid = 1'b0;
    cell_in.lat_index = '0;
    cell_in.long_index = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cell(8'd0, 8'd0);
    send_cell(8'd15, 8'd15);
    send_cell(8'd255, 8'd255);
    send_cell(8'd7, 8'd3);
    send_cell(8'd16, 8'd40);
    send_cell(8'hAA, 8'h55);
    send_cell(8'h55, 8'hAA);
    drain();

    write_register(REG_RADIUS, 32'hFFFF);
    write_register(REG_LAT_COUNT, 32'd0);
    write_register(REG_LONG_COUNT, 32'd1);
    send_cell(8'd0, 8'd0);
    send_cell(8'd1, 8'd2);
    send_cell(8'd2, 8'd1);
    send_cell(8'd5, 8'd9);
    drain();

    write_register(REG_LAT_COUNT, 32'h1FF);
    write_register(REG_LONG_COUNT, 32'd257);
    send_cell(8'd255, 8'd0);
    send_cell(8'd128, 8'd255);
    send_cell(8'd0, 8'd128);
    drain();

    write_register(REG_RADIUS, 32'd0);
    write_register(REG_LAT_COUNT, 32'd256);
    write_register(REG_LONG_COUNT, 32'd3);
    send_cell(8'd100, 8'd2);
    send_cell(8'd3, 8'd255);
    random_cells(20, 255, 5);
    drain();

    write_register(REG_RADIUS, $urandom_range(1, 65535));
    write_register(REG_LAT_COUNT, $urandom_range(3, 64));
    write_register(REG_LONG_COUNT, $urandom_range(3, 64));
    random_cells(60, 64, 64);
    drain();

    write_register(REG_RADIUS, 32'd1);
    write_register(REG_LAT_COUNT, 32'd3);
    write_register(REG_LONG_COUNT, 32'd256);
    random_cells(40, 3, 255);
    drain();

    write_register(REG_RADIUS, $urandom);
    write_register(REG_LAT_COUNT, $urandom_range(3, 256));
    write_register(REG_LONG_COUNT, $urandom_range(3, 256));
    quiet = 1'b1;
    random_cells(50, 255, 255);
    drain();

    $display("Covered %0d cells and %0d vertices over seven register settings,",
             cells_sent, vertex_count);
    $display("including minimum, maximum and clamped counts and zero and full radius.");
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/ust_pkg.sv
rtl/core/ust_cell_if.sv
rtl/core/ust_vert_if.sv
rtl/core/ust_div_cell.sv
rtl/core/ust_sine.sv
rtl/core/uv_sphere_tessellator_core.sv
bench/ust_vertex_checker.sv
bench/tb.sv
